// File: sv/jhmf_pkg.sv
// joint histogram mode finder: shared types and constants
// no dependencies

package jhmf_pkg;

    localparam int VALUE_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [VALUE_W-1:0] RANGE_LOW_RESET = 8'd18;
    localparam logic [VALUE_W-1:0] RANGE_HIGH_RESET = 8'd30;

    localparam logic REG_RANGE_LOW = 1'b0;
    localparam logic REG_RANGE_HIGH = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_COUNT,
        ST_SCAN,
        ST_DRAIN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic valid;
        logic clear;
    } store_req_t;

endpackage

// File: sv/joint_histogram_mode_finder_top.sv
// joint histogram mode finder, top level
// depends on jhmf_pkg and jhmf_store
//
// channel  direction  handshake                 payload
// s_       in         s_tvalid / s_tready       s_tdata: first_value, second_value
// m_       out        m_tvalid / m_tready       m_tdata: first_mode, second_mode,
//                                               pair_mode_first, pair_mode_second
// apb      in         psel / penable / pready   range_low at 0x0, range_high at 0x4
//
// in-range pairs are counted at one word per cycle while in the count state; each store does a
// read-modify-write with a registered read and forwards the last write to a back-to-back hit
// an out-of-range pair starts a sweep over the pair memory, then passes the drain and
// report states before the result is loaded into the output register
// after reset a clearing sweep over all BINS*BINS pair entries runs with s_tready low
// s_tready is low during sweeps; the report waits only while an older word is still held

module joint_histogram_mode_finder_top
    import jhmf_pkg::*;
#(
    parameter int BINS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // first_value [7:0], second_value [15:8]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // first_mode, second_mode, pair_mode_first,
                                             // pair_mode_second, 8 bits each from bit 0
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int BIN_W = $clog2(BINS);
    localparam int PAIRS = BINS * BINS;
    localparam int PAIR_W = $clog2(PAIRS);

    state_t state_reg, state_next;

    logic [VALUE_W-1:0] range_low_reg, range_high_reg;

    logic [BIN_W-1:0]  row_reg, col_reg, row_d_reg, col_d_reg;
    logic [PAIR_W-1:0] lin_reg;
    logic              scan_vld_reg;
    logic              sweep, sweep_last;

    logic [COUNT_WIDTH-1:0] best_first_cnt_reg, best_second_cnt_reg, best_pair_cnt_reg;
    logic [BIN_W-1:0]       best_first_idx_reg, best_second_idx_reg;
    logic [BIN_W-1:0]       best_row_reg, best_col_reg;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    logic [VALUE_W-1:0] val_a, val_b, off_a, off_b;
    logic               hit_a, hit_b, in_fire, in_hit, term, load_out;
    logic [BIN_W-1:0]   bin_a, bin_b;

    store_req_t             pair_req, first_req, second_req;
    logic [PAIR_W-1:0]      pair_addr;
    logic [BIN_W-1:0]       first_addr, second_addr;
    logic [COUNT_WIDTH-1:0] pair_rdata, first_rdata, second_rdata;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RANGE_HIGH) ? CFG_DATA_W'(range_high_reg)
                                                 : CFG_DATA_W'(range_low_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= RANGE_LOW_RESET;
            range_high_reg <= RANGE_HIGH_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_RANGE_LOW) begin
                range_low_reg <= pwdata[VALUE_W-1:0];
            end else begin
                range_high_reg <= pwdata[VALUE_W-1:0];
            end
        end
    end

    // binning
    assign val_a = s_tdata[7:0];
    assign val_b = s_tdata[15:8];
    assign off_a = val_a - range_low_reg;
    assign off_b = val_b - range_low_reg;
    assign hit_a = (val_a >= range_low_reg) && (val_a <= range_high_reg) &&
                   (off_a < VALUE_W'(BINS));
    assign hit_b = (val_b >= range_low_reg) && (val_b <= range_high_reg) &&
                   (off_b < VALUE_W'(BINS));
    assign bin_a = off_a[BIN_W-1:0];
    assign bin_b = off_b[BIN_W-1:0];

    assign s_tready = (state_reg == ST_COUNT);
    assign in_fire  = s_tvalid && s_tready;
    assign in_hit   = hit_a && hit_b;
    assign term     = in_fire && !in_hit;

    // store requests
    assign sweep      = (state_reg == ST_SCAN) || (state_reg == ST_CLEAR);
    assign sweep_last = (lin_reg == PAIR_W'(PAIRS - 1));

    always_comb begin
        if (sweep) begin
            pair_req    = '{valid: 1'b1, clear: 1'b1};
            first_req   = '{valid: (row_reg == '0), clear: 1'b1};
            second_req  = '{valid: (row_reg == '0), clear: 1'b1};
            pair_addr   = lin_reg;
            first_addr  = col_reg;
            second_addr = col_reg;
        end else begin
            pair_req    = '{valid: in_fire && in_hit, clear: 1'b0};
            first_req   = '{valid: in_fire && in_hit, clear: 1'b0};
            second_req  = '{valid: in_fire && in_hit, clear: 1'b0};
            pair_addr   = PAIR_W'(bin_a) * PAIR_W'(BINS) + PAIR_W'(bin_b);
            first_addr  = bin_a;
            second_addr = bin_b;
        end
    end

    jhmf_store #(.DEPTH(PAIRS), .CW(COUNT_WIDTH)) u_pair_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (pair_req),
        .req_addr (pair_addr),
        .rdata    (pair_rdata)
    );

    jhmf_store #(.DEPTH(BINS), .CW(COUNT_WIDTH)) u_first_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (first_req),
        .req_addr (first_addr),
        .rdata    (first_rdata)
    );

    jhmf_store #(.DEPTH(BINS), .CW(COUNT_WIDTH)) u_second_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (second_req),
        .req_addr (second_addr),
        .rdata    (second_rdata)
    );

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (sweep_last) begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (term) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sweep_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_COUNT;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // sweep counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            lin_reg      <= '0;
            scan_vld_reg <= 1'b0;
        end else begin
            scan_vld_reg <= (state_reg == ST_SCAN);
            if (sweep) begin
                if (sweep_last) begin
                    row_reg <= '0;
                    col_reg <= '0;
                    lin_reg <= '0;
                end else begin
                    lin_reg <= lin_reg + 1'b1;
                    if (col_reg == BIN_W'(BINS - 1)) begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_d_reg <= row_reg;
        col_d_reg <= col_reg;
    end

    // running maxima, strict compare keeps the lowest index on ties
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_COUNT) && term) begin
            best_first_cnt_reg  <= '0;
            best_first_idx_reg  <= '0;
            best_second_cnt_reg <= '0;
            best_second_idx_reg <= '0;
            best_pair_cnt_reg   <= '0;
            best_row_reg        <= '0;
            best_col_reg        <= '0;
        end else if (scan_vld_reg) begin
            if (row_d_reg == '0) begin
                if (first_rdata > best_first_cnt_reg) begin
                    best_first_cnt_reg <= first_rdata;
                    best_first_idx_reg <= col_d_reg;
                end
                if (second_rdata > best_second_cnt_reg) begin
                    best_second_cnt_reg <= second_rdata;
                    best_second_idx_reg <= col_d_reg;
                end
            end
            if (pair_rdata > best_pair_cnt_reg) begin
                best_pair_cnt_reg <= pair_rdata;
                best_row_reg      <= row_d_reg;
                best_col_reg      <= col_d_reg;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {VALUE_W'(range_low_reg + VALUE_W'(best_col_reg)),
                            VALUE_W'(range_low_reg + VALUE_W'(best_row_reg)),
                            VALUE_W'(range_low_reg + VALUE_W'(best_second_idx_reg)),
                            VALUE_W'(range_low_reg + VALUE_W'(best_first_idx_reg))};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/jhmf_store.sv
// one count store: synchronous memory with saturating read-modify-write and forwarding
// a request without clear increments the entry; with clear it reads the entry and zeroes it
// depends on jhmf_pkg

module jhmf_store
    import jhmf_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  store_req_t    req,
    input  logic [AW-1:0] req_addr,
    output logic [CW-1:0] rdata
);

    logic [CW-1:0] mem [DEPTH];

    logic [CW-1:0] rdata_reg;
    logic          stg_valid_reg;
    logic [AW-1:0] stg_addr_reg;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [CW-1:0] fwd_data_reg;
    logic [CW-1:0] old_count;
    logic [CW-1:0] new_count;

    // previous write has not landed in the read data yet
    assign old_count = (fwd_valid_reg && (fwd_addr_reg == stg_addr_reg)) ? fwd_data_reg
                                                                          : rdata_reg;
    assign new_count = (&old_count) ? old_count : old_count + 1'b1;
    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (stg_valid_reg) begin
            mem[stg_addr_reg] <= new_count;
        end else if (req.valid && req.clear) begin
            mem[req_addr] <= '0;
        end
        if (req.valid) begin
            rdata_reg <= mem[req_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= req.valid && !req.clear;
            fwd_valid_reg <= stg_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        stg_addr_reg <= req_addr;
        fwd_addr_reg <= stg_addr_reg;
        fwd_data_reg <= new_count;
    end

endmodule

// File: sv/jhmf_checker.sv
// port-level checks for the joint histogram mode finder
// no package dependencies; bound to joint_histogram_mode_finder_top

module jhmf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);

    // a held result word keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // input side closes only right after a word was taken
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("s_tready dropped without an accepted word");

    // a new result is loaded only while the input side is closed
    a_report_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while input was open");

    // input side reopens in the cycle the result appears
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("input did not reopen with the report");

    // configuration port never stalls
    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready went low");

endmodule

bind joint_histogram_mode_finder_top jhmf_checker u_jhmf_checker (.*);

// File: sim/tb_top.sv
// testbench for joint_histogram_mode_finder_top: random and directed pair streams with idle
// and stall phases, results checked against an in-bench histogram and mode predictor
// depends on jhmf_pkg and joint_histogram_mode_finder_top

module tb_top;
    import jhmf_pkg::*;

    localparam int BINS = 16;
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int SWEEP_CYCLES = BINS * BINS + 16;
    localparam int QUIET_LIMIT = 8 * (BINS * BINS + 64);
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS = 105;

    typedef struct packed {
        logic [VALUE_W-1:0] second_value;
        logic [VALUE_W-1:0] first_value;
    } pair_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] pair_mode_second;
        logic [VALUE_W-1:0] pair_mode_first;
        logic [VALUE_W-1:0] second_mode;
        logic [VALUE_W-1:0] first_mode;
    } modes_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;   // first_value [7:0], second_value [15:8]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;        // first_mode, second_mode, pair_mode_first,
                                           // pair_mode_second, 8 bits each from bit 0
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    joint_histogram_mode_finder_top #(
        .BINS        (BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [COUNT_WIDTH-1:0] pair_hist [BINS*BINS] = '{default: '0};
    logic [COUNT_WIDTH-1:0] first_hist [BINS] = '{default: '0};
    logic [COUNT_WIDTH-1:0] second_hist [BINS] = '{default: '0};
    logic [VALUE_W-1:0]     cur_low = RANGE_LOW_RESET;
    logic [VALUE_W-1:0]     cur_high = RANGE_HIGH_RESET;

    pair_word_t pending_pairs [$];
    modes_t     expected_modes [$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles = 0;

    function automatic bit in_window(input logic [VALUE_W-1:0] v);
        return (v >= cur_low) && (v <= cur_high) && (int'(v) - int'(cur_low) < BINS);
    endfunction

    function automatic int hist_peak(input int len, input int which);
        logic [COUNT_WIDTH-1:0] best;
        logic [COUNT_WIDTH-1:0] c;
        int best_idx;
        best = '0;
        best_idx = 0;
        for (int k = 0; k < len; k++) begin
            c = (which == 0) ? first_hist[k] : (which == 1) ? second_hist[k] : pair_hist[k];
            if (c > best) begin
                best = c;
                best_idx = k;
            end
        end
        return best_idx;
    endfunction

    function automatic void tally_pair(input pair_word_t w);
        int fb;
        int sb;
        int pm;
        modes_t r;
        if (in_window(w.first_value) && in_window(w.second_value)) begin
            fb = int'(w.first_value) - int'(cur_low);
            sb = int'(w.second_value) - int'(cur_low);
            if (pair_hist[fb*BINS+sb] != COUNT_MAX) pair_hist[fb*BINS+sb]++;
            if (first_hist[fb] != COUNT_MAX) first_hist[fb]++;
            if (second_hist[sb] != COUNT_MAX) second_hist[sb]++;
        end else begin
            pm = hist_peak(BINS * BINS, 2);
            r.first_mode = cur_low + VALUE_W'(hist_peak(BINS, 0));
            r.second_mode = cur_low + VALUE_W'(hist_peak(BINS, 1));
            r.pair_mode_first = cur_low + VALUE_W'(pm / BINS);
            r.pair_mode_second = cur_low + VALUE_W'(pm % BINS);
            expected_modes.push_back(r);
            foreach (pair_hist[k]) pair_hist[k] = '0;
            foreach (first_hist[k]) first_hist[k] = '0;
            foreach (second_hist[k]) second_hist[k] = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < 50)
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic check_modes(input modes_t got);
        modes_t want;
        if (expected_modes.size() == 0) begin
            report_mismatch("unexpected word, first_mode", got.first_mode, 8'd0);
        end else begin
            want = expected_modes.pop_front();
            if (got.first_mode !== want.first_mode)
                report_mismatch("first_mode", got.first_mode, want.first_mode);
            if (got.second_mode !== want.second_mode)
                report_mismatch("second_mode", got.second_mode, want.second_mode);
            if (got.pair_mode_first !== want.pair_mode_first)
                report_mismatch("pair_mode_first", got.pair_mode_first, want.pair_mode_first);
            if (got.pair_mode_second !== want.pair_mode_second)
                report_mismatch("pair_mode_second", got.pair_mode_second,
                                want.pair_mode_second);
        end
    endtask

    // pair driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) tally_pair(pair_word_t'(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_pairs.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_tvalid && m_tready) check_modes(modes_t'(m_tdata));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_pair(input int a, input int b);
        pair_word_t w;
        w.first_value = VALUE_W'(a);
        w.second_value = VALUE_W'(b);
        pending_pairs.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || s_tvalid || expected_modes.size() != 0)
            @(negedge aclk);
        repeat (SWEEP_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [VALUE_W-1:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_RANGE_LOW) cur_low = val;
        else cur_high = val;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    function automatic logic [VALUE_W-1:0] outside_value();
        logic [VALUE_W-1:0] v;
        do begin
            case ($urandom_range(0, 3))
                0: v = cur_low - 8'd1;
                1: v = cur_low + 8'(BINS);
                2: v = cur_high + 8'd1;
                default: v = 8'($urandom);
            endcase
        end while (in_window(v));
        return v;
    endfunction

    // runs of in-range pairs, closed by an out-of-range word unless left open, with some noise
    task automatic queue_runs(input int n_words, input bit leave_open);
        int span;
        int sub_w;
        int sub_base;
        int len;
        int done;
        pair_word_t w;
        span = 0;
        sub_w = 1;
        sub_base = cur_low;
        done = 0;
        if (cur_low <= cur_high)
            span = (int'(cur_high) - int'(cur_low) + 1 < BINS) ?
                   int'(cur_high) - int'(cur_low) + 1 : BINS;
        while (done < n_words) begin
            len = $urandom_range(0, 24);
            if (span > 0) begin
                sub_w = $urandom_range(1, span);
                sub_base = int'(cur_low) + $urandom_range(0, span - sub_w);
            end
            for (int k = 0; k < len && done < n_words; k++) begin
                if (span == 0 || $urandom_range(0, 99) < 4) begin
                    w = pair_word_t'(16'($urandom));
                end else begin
                    w.first_value = VALUE_W'(sub_base + $urandom_range(0, sub_w - 1));
                    w.second_value = VALUE_W'(sub_base + $urandom_range(0, sub_w - 1));
                end
                pending_pairs.push_back(w);
                done++;
            end
            if (!(leave_open && done >= n_words)) begin
                case ($urandom_range(0, 2))
                    0: begin
                        w.first_value = outside_value();
                        w.second_value = 8'($urandom);
                    end
                    1: begin
                        w.first_value = 8'($urandom);
                        w.second_value = outside_value();
                    end
                    default: begin
                        w.first_value = outside_value();
                        w.second_value = outside_value();
                    end
                endcase
                pending_pairs.push_back(w);
                done++;
            end
        end
    endtask

    initial begin
        int lows [6];
        int highs [6];
        int lo;
        int hi;
        lows = '{0, 240, 255, 0, 100, 7};
        highs = '{255, 255, 255, 0, 50, 15};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset range 18..30: empty store, ties, each side out of range, field extremes
        push_pair(0, 0);
        push_pair(18, 18);
        push_pair(30, 30);
        push_pair(30, 30);
        push_pair(18, 30);
        push_pair(17, 20);
        push_pair(20, 25);
        push_pair(22, 19);
        push_pair(22, 19);
        push_pair(20, 25);
        push_pair(20, 31);
        push_pair(25, 25);
        push_pair(255, 255);
        push_pair(18, 18);
        push_pair(0, 255);
        push_pair(19, 19);
        push_pair(31, 19);
        push_pair(255, 0);
        push_pair(29, 21);
        push_pair(21, 17);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 6) begin
                lo = lows[p];
                hi = highs[p];
            end else begin
                lo = $urandom_range(0, 255);
                if ($urandom_range(0, 99) < 80) hi = lo + $urandom_range(0, 24);
                else hi = $urandom_range(0, 255);
                if (hi > 255) hi = 255;
            end
            write_reg(REG_RANGE_LOW, VALUE_W'(lo));
            write_reg(REG_RANGE_HIGH, VALUE_W'(hi));
            set_idling(p % 4);
            // odd phases leave a run open so the next setting applies mid-run
            queue_runs(PHASE_WORDS, p[0]);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
